### hdl/frq_pkg.sv
package frq_pkg;

    localparam int QUEUE_DEPTH_DEF = 10;
    localparam logic [3:0] TOP_FLOOR_RST = 4'd9;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_WRONG = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] floor;
    } frq_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] taken_floor;
        logic [3:0] head_floor;
        logic       head_valid;
        logic [3:0] count;
    } frq_out_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } frq_cmd_t;

endpackage

### hdl/floor_request_queue.sv
// Floor request queue: a first-in first-out queue of up to QUEUE_DEPTH floors
// that refuses duplicates. Each item (add, take head, clear) produces exactly
// one result showing status, the floor taken, the new head and the count.
// The entries sit in a row of cells that compare against the requested floor
// in parallel and shift toward the head on a take, and the result is held in
// an output register, so a new item is accepted in every cycle in which the
// result register is empty or being drained.
// top_floor (reset 9) bounds both the floor range and the fill level; write it
// through the cfg channel only while the queue is idle.
module floor_request_queue #(
    parameter int QUEUE_DEPTH = frq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  frq_pkg::frq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output frq_pkg::frq_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data
);
    import frq_pkg::*;

    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    logic [3:0]    entry_w [QUEUE_DEPTH];
    logic          valid_w [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] match_w;

    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    top_floor_reg;
    logic          m_valid_reg, m_valid_next;
    frq_out_t      out_reg, out_next;
    frq_cmd_t      cmd;

    logic          acc, dup, full, wrong;
    logic [CMPW-1:0] count_ext, top_ext;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic       prev_v;
            logic [3:0] nb_e;
            logic       nb_v;
            if (gi == 0) begin : g_first
                assign prev_v = 1'b1;
            end else begin : g_mid
                assign prev_v = valid_w[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign nb_e = 4'd0;
                assign nb_v = 1'b0;
            end else begin : g_inner
                assign nb_e = entry_w[gi+1];
                assign nb_v = valid_w[gi+1];
            end
            frq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .cmd        (cmd),
                .new_floor  (s_data.floor),
                .prev_valid (prev_v),
                .nb_entry   (nb_e),
                .nb_valid   (nb_v),
                .entry      (entry_w[gi]),
                .valid      (valid_w[gi]),
                .match      (match_w[gi])
            );
        end
    endgenerate

    assign s_ready   = !m_valid_reg || m_ready;
    assign acc       = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign count_ext = CMPW'(count_reg);
    assign top_ext   = CMPW'(top_floor_reg);
    assign dup       = |match_w;
    assign full      = (count_ext > top_ext) || (count_reg == CW'(QUEUE_DEPTH));
    assign wrong     = s_data.floor > top_floor_reg;

    always_comb begin
        cmd.load  = acc && (s_data.action == ACT_ADD) && !dup && !full && !wrong;
        cmd.shift = acc && (s_data.action == ACT_TAKE) && valid_w[0];
        cmd.clear = acc && (s_data.action == ACT_CLEAR);
    end

    always_comb begin
        count_next = count_reg;
        out_next   = out_reg;
        if (acc) begin
            out_next.status      = ST_OK;
            out_next.taken_floor = 4'd0;
            out_next.head_valid  = valid_w[0];
            out_next.head_floor  = valid_w[0] ? entry_w[0] : 4'd0;
            case (s_data.action)
                ACT_ADD: begin
                    if (dup) begin
                        out_next.status = ST_DUP;
                    end else if (full) begin
                        out_next.status = ST_FULL;
                    end else if (wrong) begin
                        out_next.status = ST_WRONG;
                    end else begin
                        count_next          = count_reg + CW'(1);
                        out_next.head_valid = 1'b1;
                        out_next.head_floor = valid_w[0] ? entry_w[0] : s_data.floor;
                    end
                end
                ACT_TAKE: begin
                    if (!valid_w[0]) begin
                        out_next.status = ST_EMPTY;
                    end else begin
                        count_next           = count_reg - CW'(1);
                        out_next.taken_floor = entry_w[0];
                        out_next.head_valid  = valid_w[1];
                        out_next.head_floor  = valid_w[1] ? entry_w[1] : 4'd0;
                    end
                end
                ACT_CLEAR: begin
                    count_next          = '0;
                    out_next.head_valid = 1'b0;
                    out_next.head_floor = 4'd0;
                end
                default: begin
                end
            endcase
            out_next.count = 4'(count_next);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (acc) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            top_floor_reg <= TOP_FLOOR_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                top_floor_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### hdl/frq_cell.sv
module frq_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  frq_pkg::frq_cmd_t cmd,
    input  logic [3:0]        new_floor,
    input  logic              prev_valid,
    input  logic [3:0]        nb_entry,
    input  logic              nb_valid,
    output logic [3:0]        entry,
    output logic              valid,
    output logic              match
);
    import frq_pkg::*;

    logic [3:0] entry_reg, entry_next;
    logic       valid_reg, valid_next;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.clear) begin
            valid_next = 1'b0;
        end else if (cmd.shift) begin
            entry_next = nb_entry;
            valid_next = nb_valid;
        end else if (cmd.load && prev_valid && !valid_reg) begin
            entry_next = new_floor;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (entry_reg == new_floor);

endmodule
